### rtl/qpht_pkg.sv
// shared types and constants for the quadratic probing hash table
// no dependencies; imported by every module of the block except qpht_ram
package qpht_pkg;

    localparam int SLOTS        = 16;
    localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PROBE_W      = $clog2(SLOTS + 1);
    localparam int REM_W        = SLOT_W + 1;
    localparam bit SLOTS_POW2   = ((SLOTS & (SLOTS - 1)) == 0);
    localparam int KEY_W        = 31;
    localparam int SLOT_FIELD_W = 4;

    // home slot reduction for tables that are not a power of two
    localparam int DIGIT_BITS   = 4;
    localparam int RED_STEPS    = (KEY_W + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int RED_CNT_W    = $clog2(RED_STEPS + 1);
    localparam int RED_PAD_W    = RED_STEPS * DIGIT_BITS;

    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_REMOVE = 2'd2
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_REMOVED   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_SEARCH,
        OP_REMOVE,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PROBE,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] key;
    } cmd_t;

    typedef struct packed {
        status_t                 status;
        logic [SLOT_FIELD_W-1:0] slot;
    } res_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [SLOT_W-1:0] home;
    } q_entry_t;

    function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] s);
        logic [SLOT_W+SLOT_FIELD_W-1:0] wide;
        wide = {{SLOT_FIELD_W{1'b0}}, s};
        return wide[SLOT_FIELD_W-1:0];
    endfunction

endpackage

### rtl/qpht_ram.sv
// generic single write port, single read port ram with registered read
// standalone, no package needed
module qpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/qpht_front.sv
// front end: takes requests, decodes the command and works out the home slot
// depends on qpht_pkg
module qpht_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  qpht_pkg::cmd_t   cmd_data,
    input  logic             q_full,
    output logic             q_push,
    output qpht_pkg::q_entry_t q_wdata
);

    import qpht_pkg::*;

    logic                 hold_reg,  hold_next;
    logic [1:0]           cmd_reg,   cmd_next;
    logic [KEY_W-1:0]     key_reg,   key_next;
    logic [RED_PAD_W-1:0] sh_reg,    sh_next;
    logic [REM_W-1:0]     rem_reg,   rem_next;
    logic [RED_CNT_W-1:0] cnt_reg,   cnt_next;

    logic                 done;
    logic                 accept;
    logic [REM_W-1:0]     rem_step;
    logic [RED_PAD_W-1:0] sh_step;
    op_t                  op;

    // one digit of the key per cycle, msb first, remainder kept below SLOTS
    always_comb
    begin
        logic [REM_W-1:0]     r;
        logic [RED_PAD_W-1:0] sh;
        r  = rem_reg;
        sh = sh_reg;
        for (int k = 0; k < DIGIT_BITS; k++)
        begin
            r  = {r[SLOT_W-1:0], sh[RED_PAD_W-1]};
            sh = sh << 1;
            if (r >= REM_W'(SLOTS))
            begin
                r = r - REM_W'(SLOTS);
            end
        end
        rem_step = r;
        sh_step  = sh;
    end

    assign done      = hold_reg && (SLOTS_POW2 || (cnt_reg == RED_CNT_W'(RED_STEPS)));
    assign q_push    = done && !q_full;
    assign cmd_stall = hold_reg && !q_push;
    assign accept    = cmd_valid && !cmd_stall;

    always_comb
    begin
        case (cmd_reg)
            CMD_INSERT: op = OP_INSERT;
            CMD_SEARCH: op = OP_SEARCH;
            CMD_REMOVE: op = OP_REMOVE;
            default:    op = OP_NONE;
        endcase
    end

    always_comb
    begin
        q_wdata.op  = op;
        q_wdata.key = key_reg;
        if (SLOTS_POW2)
        begin
            q_wdata.home = key_reg[SLOT_W-1:0];
        end
        else
        begin
            q_wdata.home = rem_reg[SLOT_W-1:0];
        end
    end

    always_comb
    begin
        hold_next = hold_reg;
        cmd_next  = cmd_reg;
        key_next  = key_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            hold_next = 1'b1;
            cmd_next  = cmd_data.command;
            key_next  = cmd_data.key;
            sh_next   = RED_PAD_W'(cmd_data.key);
            rem_next  = '0;
            cnt_next  = '0;
        end
        else if (q_push)
        begin
            hold_next = 1'b0;
        end
        else if (hold_reg && !done)
        begin
            rem_next = rem_step;
            sh_next  = sh_step;
            cnt_next = cnt_reg + RED_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
        end
        else
        begin
            hold_reg <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        key_reg <= key_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

endmodule

### rtl/qpht_queue.sv
// short fifo of decoded commands between front end and probe engine
// depends on qpht_pkg
module qpht_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  qpht_pkg::q_entry_t wdata,
    output logic               full,
    input  logic               pop,
    output qpht_pkg::q_entry_t rdata,
    output logic               empty
);

    import qpht_pkg::*;

    q_entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg,    cnt_next;

    assign full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/qpht_back.sv
// probe engine: walks the quadratic probe sequence and updates the table
// depends on qpht_pkg and qpht_ram
module qpht_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  qpht_pkg::q_entry_t q_rdata,
    output logic               q_pop,
    output logic               res_valid,
    input  logic               res_stall,
    output qpht_pkg::res_t     res_data
);

    import qpht_pkg::*;

    back_state_t         state_reg,      state_next;
    op_t                 op_reg,         op_next;
    logic [KEY_W-1:0]    key_reg,        key_next;
    logic [SLOT_W-1:0]   s_reg,          s_next;
    logic [SLOT_W-1:0]   delta_reg,      delta_next;
    logic [PROBE_W-1:0]  cnt_reg,        cnt_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]   pend_slot_reg,  pend_slot_next;
    logic [SLOTS-1:0]    used_reg,       used_next;
    status_t             st_reg,         st_next;
    logic [SLOT_W-1:0]   rslot_reg,      rslot_next;
    logic                out_valid_reg,  out_valid_next;
    res_t                out_data_reg,   out_data_next;

    logic                ram_we;
    logic                ram_re;
    logic [KEY_W-1:0]    ram_rdata;
    logic [REM_W-1:0]    s_sum;
    logic [REM_W-1:0]    d_sum;
    logic [SLOT_W-1:0]   s_adv;
    logic [SLOT_W-1:0]   delta_adv;
    logic                out_free;
    logic                match;

    qpht_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOTS)
    ) u_key_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s_reg),
        .wdata (key_reg),
        .re    (ram_re),
        .raddr (s_reg),
        .rdata (ram_rdata)
    );

    // next probe: offset grows by 2i+1, both kept below SLOTS
    always_comb
    begin
        s_sum = {1'b0, s_reg} + {1'b0, delta_reg};
        if (s_sum >= REM_W'(SLOTS))
        begin
            s_sum = s_sum - REM_W'(SLOTS);
        end
        d_sum = {1'b0, delta_reg} + REM_W'(2);
        if (d_sum >= REM_W'(SLOTS))
        begin
            d_sum = d_sum - REM_W'(SLOTS);
        end
        s_adv     = s_sum[SLOT_W-1:0];
        delta_adv = d_sum[SLOT_W-1:0];
    end

    assign out_free  = !out_valid_reg || !res_stall;
    assign match     = pend_valid_reg && (ram_rdata == key_reg);
    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        s_next          = s_reg;
        delta_next      = delta_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        used_next       = used_reg;
        st_next         = st_reg;
        rslot_next      = rslot_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop           = 1'b1;
                    op_next         = q_rdata.op;
                    key_next        = q_rdata.key;
                    s_next          = q_rdata.home;
                    delta_next      = SLOT_W'(1);
                    cnt_next        = '0;
                    pend_valid_next = 1'b0;
                    state_next      = BK_PROBE;
                end
            end
            BK_PROBE:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (cnt_reg == PROBE_W'(SLOTS))
                        begin
                            st_next    = ST_FULL;
                            rslot_next = '0;
                            state_next = BK_EMIT;
                        end
                        else if (!used_reg[s_reg])
                        begin
                            ram_we           = 1'b1;
                            used_next[s_reg] = 1'b1;
                            st_next          = ST_INSERTED;
                            rslot_next       = s_reg;
                            state_next       = BK_EMIT;
                        end
                        else
                        begin
                            s_next     = s_adv;
                            delta_next = delta_adv;
                            cnt_next   = cnt_reg + PROBE_W'(1);
                        end
                    end
                    OP_SEARCH, OP_REMOVE:
                    begin
                        // compare of the previous probe resolves before the current one
                        if (match)
                        begin
                            if (op_reg == OP_REMOVE)
                            begin
                                used_next[pend_slot_reg] = 1'b0;
                                st_next = ST_REMOVED;
                            end
                            else
                            begin
                                st_next = ST_FOUND;
                            end
                            rslot_next = pend_slot_reg;
                            state_next = BK_EMIT;
                        end
                        else if (cnt_reg == PROBE_W'(SLOTS) || !used_reg[s_reg])
                        begin
                            st_next    = ST_NOT_FOUND;
                            rslot_next = '0;
                            state_next = BK_EMIT;
                        end
                        else
                        begin
                            ram_re          = 1'b1;
                            pend_valid_next = 1'b1;
                            pend_slot_next  = s_reg;
                            s_next          = s_adv;
                            delta_next      = delta_adv;
                            cnt_next        = cnt_reg + PROBE_W'(1);
                        end
                    end
                    default:
                    begin
                        st_next    = ST_NOT_FOUND;
                        rslot_next = '0;
                        state_next = BK_EMIT;
                    end
                endcase
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_data_next.status = st_reg;
                    out_data_next.slot   = slot_field(rslot_reg);
                    state_next           = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        s_reg         <= s_next;
        delta_reg     <= delta_next;
        cnt_reg       <= cnt_next;
        pend_slot_reg <= pend_slot_next;
        st_reg        <= st_next;
        rslot_reg     <= rslot_next;
        out_data_reg  <= out_data_next;
    end

endmodule

### rtl/quadratic_probe_hash_table_top.sv
// Open-addressing key set with quadratic probing over SLOTS entries (16 here).
// A request carries insert, search or remove and a 31-bit key; each request
// returns one result with a status and the slot acted upon. The front end
// decodes the request and reduces the key to its home slot (directly from the low
// key bits when SLOTS is a power of two, otherwise by a digit-serial remainder);
// it hands the work to the probe engine through a two-entry queue, so it can
// take the next request while the engine is busy. The engine visits one probe
// slot per cycle, reading keys from a key ram with one write port, one read
// port and a registered read; it works on one item at a time and pops the
// next one only after handing the last result to the output register.
// Occupancy bits are cleared at reset; no clearing pass is needed.
// depends on qpht_pkg, qpht_front, qpht_queue, qpht_back
module quadratic_probe_hash_table_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  qpht_pkg::cmd_t   cmd_data,
    output logic             res_valid,
    input  logic             res_stall,
    output qpht_pkg::res_t   res_data
);

    import qpht_pkg::*;

    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;
    q_entry_t q_wdata;
    q_entry_t q_rdata;

    qpht_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    qpht_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    qpht_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

### test/qpht_result_checker.sv
// checker for the quadratic probing hash table: keeps a shadow copy of the key table,
// predicts the result of each accepted request and compares it with the block's output
// depends on qpht_pkg
module qpht_result_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  logic            cmd_stall,
    input  qpht_pkg::cmd_t  cmd_data,
    input  logic            res_valid,
    input  logic            res_stall,
    input  qpht_pkg::res_t  res_data,
    output int              fails,
    output int              outstanding,
    output int              checked
);
    import qpht_pkg::*;

    logic [KEY_W-1:0] shadow_key  [SLOTS];
    bit               shadow_used [SLOTS];
    res_t             predicted_results [$];
    res_t             want;

    function automatic int unsigned probe_slot(input logic [KEY_W-1:0] k,
                                               input int unsigned i);
        int unsigned home;
        home = k % SLOTS;
        return (home + i * i) % SLOTS;
    endfunction

    // walks the probe chain; stops at the first free slot or a matching key
    function automatic int find_key(input logic [KEY_W-1:0] k);
        int unsigned i;
        int unsigned s;
        for (i = 0; i < SLOTS; i++)
        begin
            s = probe_slot(k, i);
            if (!shadow_used[s])
                return -1;
            if (shadow_key[s] == k)
                return int'(s);
        end
        return -1;
    endfunction

    function automatic res_t apply_request(input cmd_t req);
        res_t        r;
        int unsigned i;
        int unsigned s;
        int          where;
        bit          placed;
        r.status = ST_NOT_FOUND;
        r.slot   = '0;
        placed   = 1'b0;
        case (req.command)
            CMD_INSERT:
            begin
                // no duplicate check, and slots off the probe chain stay unreachable
                r.status = ST_FULL;
                for (i = 0; i < SLOTS && !placed; i++)
                begin
                    s = probe_slot(req.key, i);
                    if (!shadow_used[s])
                    begin
                        shadow_used[s] = 1'b1;
                        shadow_key[s]  = req.key;
                        r.status       = ST_INSERTED;
                        r.slot         = SLOT_FIELD_W'(s);
                        placed         = 1'b1;
                    end
                end
            end
            CMD_SEARCH:
            begin
                where = find_key(req.key);
                if (where >= 0)
                begin
                    r.status = ST_FOUND;
                    r.slot   = SLOT_FIELD_W'(where);
                end
            end
            CMD_REMOVE:
            begin
                where = find_key(req.key);
                if (where >= 0)
                begin
                    // freed outright, no tombstone left behind
                    shadow_used[where] = 1'b0;
                    r.status           = ST_REMOVED;
                    r.slot             = SLOT_FIELD_W'(where);
                end
            end
            default:
            begin
                // unused code: no state change, answered as a miss
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (shadow_used[n])
                shadow_used[n] = 1'b0;
            predicted_results.delete();
            fails = 0;
            outstanding <= 0;
            checked <= 0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
                predicted_results.push_back(apply_request(cmd_data));
            if (res_valid && !res_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("%0t: unexpected result, status %0d slot %0d",
                             $time, res_data.status, res_data.slot);
                    fails++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (res_data.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, res_data.status);
                        fails++;
                    end
                    if (res_data.slot !== want.slot)
                    begin
                        $display("%0t: slot mismatch, expected %0d actual %0d",
                                 $time, want.slot, res_data.slot);
                        fails++;
                    end
                    checked <= checked + 1;
                end
            end
            outstanding <= predicted_results.size();
        end
    end

endmodule

### test/quadratic_probe_hash_table_top_tb.sv
// testbench top for the quadratic probing hash table: clock, reset, request stimulus,
// result back-pressure and the final verdict
// depends on qpht_pkg, quadratic_probe_hash_table_top and qpht_result_checker
module quadratic_probe_hash_table_top_tb;
    import qpht_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 120;
    localparam int CALM_FROM    = 450;
    localparam int CALM_TO      = 600;
    localparam int DRAIN_AT     = 720;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd_data  = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res_data;

    int fails;
    int outstanding;
    int checked;
    int cycle_count = 0;
    int sent [4];
    bit calm      = 1'b0;
    bit hold_go   = 1'b0;
    bit hold_done = 1'b0;

    logic [KEY_W-1:0] live_keys [$];

    quadratic_probe_hash_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    qpht_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd_data    (cmd_data),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_data    (res_data),
        .fails       (fails),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_count, outstanding);
        $display("Regression FAIL");
        $finish;
    end

    // result side: random stalls, one long hold-off, none during the calm stretch
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
                res_stall <= 1'b0;
            end
            else if (calm)
                res_stall <= 1'b0;
            else
                res_stall <= ($urandom_range(0, 99) < 7);
        end
    end

    task automatic offer(input logic [1:0] code, input logic [KEY_W-1:0] k);
        while (!calm && $urandom_range(0, 99) < 7)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= '{command: code, key: k};
        do @(posedge clk); while (cmd_stall);
        sent[code]++;
    endtask

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        k = KEY_W'($urandom());
        case ($urandom_range(0, 9))
            0, 1: k = KEY_W'($urandom_range(0, 63));
            // crowd a few home slots so probe chains collide
            2, 3, 4, 5: k[SLOT_W-1:0] = SLOT_W'($urandom_range(0, 3));
            default: ;
        endcase
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] known_or_fresh();
        if (live_keys.size() > 0 && $urandom_range(0, 3) != 0)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        return fresh_key();
    endfunction

    initial
    begin
        int               n;
        int               pick;
        int               idx;
        logic [KEY_W-1:0] k;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // home slot 0 chain: slots 0, 1, 4, 9, then full
        offer(CMD_INSERT, 31'd0);
        offer(CMD_INSERT, 31'd16);
        offer(CMD_INSERT, 31'd32);
        offer(CMD_INSERT, 31'd48);
        offer(CMD_INSERT, 31'd64);
        offer(CMD_SEARCH, 31'd48);
        offer(CMD_SEARCH, 31'd80);
        // a freed slot ends the chain early for keys behind it
        offer(CMD_REMOVE, 31'd16);
        offer(CMD_SEARCH, 31'd32);
        offer(CMD_INSERT, 31'h7FFF_FFFF);
        offer(CMD_SEARCH, 31'h7FFF_FFFF);
        offer(CMD_INSERT, 31'h7FFF_FFF0);
        offer(CMD_INSERT, 31'd0);
        offer(CMD_REMOVE, 31'h7FFF_FFFF);
        offer(CMD_REMOVE, 31'h7FFF_FFFF);
        offer(CMD_UNUSED, 31'd0);
        offer(CMD_UNUSED, 31'h7FFF_FFFF);
        offer(CMD_SEARCH, 31'd0);
        offer(CMD_SEARCH, 31'h2AAA_AAAA);
        offer(CMD_SEARCH, 31'h5555_5555);
        offer(CMD_REMOVE, 31'h7FFF_FFF0);
        offer(CMD_REMOVE, 31'd48);
        offer(CMD_REMOVE, 31'd0);
        offer(CMD_REMOVE, 31'd32);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == HOLD_AT)
                hold_go <= 1'b1;
            if (n == CALM_FROM)
                calm <= 1'b1;
            if (n == CALM_TO)
                calm <= 1'b0;
            if (n == DRAIN_AT)
            begin
                cmd_valid <= 1'b0;
                do @(posedge clk); while (outstanding != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 36)
            begin
                k = ($urandom_range(0, 9) == 0) ? known_or_fresh() : fresh_key();
                offer(CMD_INSERT, k);
                live_keys.push_back(k);
                if (live_keys.size() > 40)
                    live_keys.delete(0);
            end
            else if (pick < 64)
                offer(CMD_SEARCH, known_or_fresh());
            else if (pick < 96)
            begin
                if (live_keys.size() > 0 && $urandom_range(0, 4) != 0)
                begin
                    idx = $urandom_range(0, live_keys.size() - 1);
                    k   = live_keys[idx];
                    live_keys.delete(idx);
                end
                else
                    k = fresh_key();
                offer(CMD_REMOVE, k);
            end
            else
                offer(CMD_UNUSED, fresh_key());
        end

        cmd_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d inserts, %0d searches, %0d removes, %0d unused-code requests",
                 sent[CMD_INSERT], sent[CMD_SEARCH], sent[CMD_REMOVE], sent[CMD_UNUSED]);
        $display("%0d results compared across a long result hold-off and a full drain pause",
                 checked);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
